/* rtl/iloc_pkg.sv */
package iloc_pkg;

    // parser phase
    typedef enum logic [4:0] {
        PH_WAIT      = 5'd0,
        PH_HDR       = 5'd1,
        PH_SIZES1    = 5'd2,
        PH_SIZES2    = 5'd3,
        PH_ITEMCOUNT = 5'd4,
        PH_ITEMID    = 5'd5,
        PH_METHOD    = 5'd6,
        PH_DATAREF   = 5'd7,
        PH_BASEOFF   = 5'd8,
        PH_EXTCOUNT  = 5'd9,
        PH_EXTINDEX  = 5'd10,
        PH_EXTOFF    = 5'd11,
        PH_EXTLEN    = 5'd12
    } t_phase;

    // record kinds
    localparam logic [1:0] KIND_EXTENT = 2'd0;
    localparam logic [1:0] KIND_NOEXT  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_OFFSET_SIZE = 3'd0;
    localparam logic [2:0] ERR_LENGTH_SIZE = 3'd1;
    localparam logic [2:0] ERR_BASE_SIZE   = 3'd2;
    localparam logic [2:0] ERR_INDEX_SIZE  = 3'd3;
    localparam logic [2:0] ERR_VERSION     = 3'd4;

    // byte lengths of the fixed fields
    localparam logic [3:0] LEN_HDR    = 4'd4;
    localparam logic [3:0] LEN_NIBBLE = 4'd1;
    localparam logic [3:0] LEN_SHORT  = 4'd2;
    localparam logic [3:0] LEN_LONG   = 4'd4;

    localparam logic [7:0] VERSION_WIDE_IDS = 8'd2;
    localparam logic [7:0] VERSION_MAX      = 8'd2;

    // one output record
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [31:0] item_id;
        logic [2:0]  method;
        logic [15:0] data_ref;
        logic [63:0] base_offset;
        logic [63:0] ext_index;
        logic [63:0] ext_offset;
        logic [63:0] ext_length;
        logic        last_item;
        logic        last_box;
    } t_rec;

    // field size nibble must be 0, 4 or 8
    function automatic logic size_ok(input logic [3:0] s);
        return (s == 4'd0) || (s == 4'd4) || (s == 4'd8);
    endfunction

endpackage

/* rtl/item_location_box_parser.sv */
// a record is registered into the output or skid register as its final byte is accepted
// throughput: one byte per cycle while o_s_tready is high; each byte is one state update
// a two-entry output buffer (output register plus skid register) absorbs master stalls
// o_s_tready drops only while both output entries are full
// reset is synchronous, active low, and returns the parser to waiting for a box start
module item_location_box_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [7:0]     i_s_tdata,   // data_byte
    input  logic [0:0]     i_s_tuser,   // box_start
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    // error_code, item_id, construction_method, data_reference_index, base_offset,
    // extent_index, extent_offset, extent_length, zero pad
    output logic [311:0]   o_m_tdata,
    output logic [2:0]     o_m_tuser,   // record_kind, last_of_item
    output logic           o_m_tlast    // last_of_box
);
    import iloc_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [7:0]  r_version, n_version;
    logic [3:0]  r_off_sz, n_off_sz;
    logic [3:0]  r_len_sz, n_len_sz;
    logic [3:0]  r_base_sz, n_base_sz;
    logic [3:0]  r_idx_sz, n_idx_sz;
    logic [31:0] r_items, n_items;
    logic [15:0] r_exts, n_exts;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_hid, n_hid;
    logic [2:0]  r_hmeth, n_hmeth;
    logic [15:0] r_hdref, n_hdref;
    logic [63:0] r_hbase, n_hbase;
    logic [63:0] r_hidx, n_hidx;
    logic [63:0] r_hoff, n_hoff;

    logic        r_out_valid, r_skid_valid;
    t_rec        r_out, r_skid;

    t_rec        res;
    logic        res_v;
    logic        s_fire;
    logic        out_fire;

    assign o_s_tready = !r_skid_valid;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_fire   = r_out_valid && i_m_tready;

    // field length in bytes for a phase
    function automatic logic [3:0] field_len(input t_phase ph, input logic [7:0] ver,
                                             input logic [3:0] base_sz,
                                             input logic [3:0] idx_sz,
                                             input logic [3:0] off_sz,
                                             input logic [3:0] len_sz);
        logic [3:0] l;
        begin
            case (ph)
                PH_HDR:                  l = LEN_HDR;
                PH_SIZES1, PH_SIZES2:    l = LEN_NIBBLE;
                PH_ITEMCOUNT, PH_ITEMID: l = (ver == VERSION_WIDE_IDS) ? LEN_LONG : LEN_SHORT;
                PH_METHOD, PH_DATAREF,
                PH_EXTCOUNT:             l = LEN_SHORT;
                PH_BASEOFF:              l = base_sz;
                PH_EXTINDEX:             l = idx_sz;
                PH_EXTOFF:               l = off_sz;
                PH_EXTLEN:               l = len_sz;
                default:                 l = LEN_NIBBLE;
            endcase
            return l;
        end
    endfunction

    // byte parser: one state update per accepted byte
    always_comb begin
        t_phase      ph;
        logic [3:0]  cnt;
        logic [3:0]  cnt1;
        logic [63:0] v;
        logic        wide;
        logic        fin;
        logic [63:0] fin_len;
        logic [63:0] fin_idx;
        logic [63:0] fin_off;
        logic        item_end;
        logic [15:0] ext_dec;
        logic [3:0]  idx_new;

        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_version = r_version;
        n_off_sz  = r_off_sz;
        n_len_sz  = r_len_sz;
        n_base_sz = r_base_sz;
        n_idx_sz  = r_idx_sz;
        n_items   = r_items;
        n_exts    = r_exts;
        n_acc     = r_acc;
        n_hid     = r_hid;
        n_hmeth   = r_hmeth;
        n_hdref   = r_hdref;
        n_hbase   = r_hbase;
        n_hidx    = r_hidx;
        n_hoff    = r_hoff;
        res       = '0;
        res_v     = 1'b0;

        ph       = i_s_tuser[0] ? PH_HDR : r_phase;
        cnt      = i_s_tuser[0] ? 4'd0 : r_cnt;
        cnt1     = cnt + 4'd1;
        v        = {((cnt == 4'd0) ? 56'd0 : r_acc[55:0]), i_s_tdata};
        wide     = (r_version == 8'd1) || (r_version == 8'd2);
        fin      = 1'b0;
        fin_len  = '0;
        fin_idx  = '0;
        fin_off  = '0;
        item_end = 1'b0;
        ext_dec  = r_exts - 16'd1;
        idx_new  = wide ? v[3:0] : 4'd0;

        if (s_fire && (ph != PH_WAIT)) begin
            n_phase = ph;
            n_acc   = v;
            n_cnt   = cnt1;
            if (cnt1 >= field_len(ph, r_version, r_base_sz, r_idx_sz, r_off_sz, r_len_sz))
            begin
                n_cnt = 4'd0;
                case (ph)
                    PH_HDR: begin
                        n_version = v[31:24];
                        n_phase   = PH_SIZES1;
                    end
                    PH_SIZES1: begin
                        n_off_sz = v[7:4];
                        n_len_sz = v[3:0];
                        if (!size_ok(v[7:4])) begin
                            res_v = 1'b1;
                            res.kind = KIND_ERROR;
                            res.err = ERR_OFFSET_SIZE;
                            res.last_box = 1'b1;
                            n_phase = PH_WAIT;
                        end else if (!size_ok(v[3:0])) begin
                            res_v = 1'b1;
                            res.kind = KIND_ERROR;
                            res.err = ERR_LENGTH_SIZE;
                            res.last_box = 1'b1;
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_SIZES2;
                        end
                    end
                    PH_SIZES2: begin
                        n_base_sz = v[7:4];
                        n_idx_sz  = idx_new;
                        if (!size_ok(v[7:4])) begin
                            res_v = 1'b1;
                            res.kind = KIND_ERROR;
                            res.err = ERR_BASE_SIZE;
                            res.last_box = 1'b1;
                            n_phase = PH_WAIT;
                        end else if (!size_ok(idx_new)) begin
                            res_v = 1'b1;
                            res.kind = KIND_ERROR;
                            res.err = ERR_INDEX_SIZE;
                            res.last_box = 1'b1;
                            n_phase = PH_WAIT;
                        end else if (r_version > VERSION_MAX) begin
                            res_v = 1'b1;
                            res.kind = KIND_ERROR;
                            res.err = ERR_VERSION;
                            res.last_box = 1'b1;
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_ITEMCOUNT;
                        end
                    end
                    PH_ITEMCOUNT: begin
                        n_items = v[31:0];
                        if (v[31:0] == 32'd0) begin
                            res_v = 1'b1;
                            res.kind = KIND_EMPTY;
                            res.last_box = 1'b1;
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_ITEMID;
                        end
                    end
                    PH_ITEMID: begin
                        n_hid   = v[31:0];
                        n_hmeth = 3'd0;
                        n_phase = wide ? PH_METHOD : PH_DATAREF;
                    end
                    PH_METHOD: begin
                        n_hmeth = v[2:0];
                        n_phase = PH_DATAREF;
                    end
                    PH_DATAREF: begin
                        n_hdref = v[15:0];
                        n_hbase = '0;
                        n_phase = (r_base_sz != 4'd0) ? PH_BASEOFF : PH_EXTCOUNT;
                    end
                    PH_BASEOFF: begin
                        n_hbase = v;
                        n_phase = PH_EXTCOUNT;
                    end
                    PH_EXTCOUNT: begin
                        n_exts = v[15:0];
                        n_hidx = '0;
                        n_hoff = '0;
                        if (v[15:0] == 16'd0) begin
                            res_v = 1'b1;
                            res.kind = KIND_NOEXT;
                            item_end = 1'b1;
                        end else if (wide && (r_idx_sz != 4'd0)) begin
                            n_phase = PH_EXTINDEX;
                        end else if (r_off_sz != 4'd0) begin
                            n_phase = PH_EXTOFF;
                        end else if (r_len_sz != 4'd0) begin
                            n_phase = PH_EXTLEN;
                        end else begin
                            // extents without bytes collapse into one record
                            res_v = 1'b1;
                            res.kind = KIND_EXTENT;
                            item_end = 1'b1;
                        end
                        if (item_end) begin
                            res.item_id   = r_hid;
                            res.method    = r_hmeth;
                            res.data_ref  = r_hdref;
                            res.base_offset = r_hbase;
                            res.last_item = 1'b1;
                            res.last_box  = (r_items == 32'd1);
                        end
                    end
                    PH_EXTINDEX: begin
                        n_hidx = v;
                        if (r_off_sz != 4'd0) begin
                            n_phase = PH_EXTOFF;
                        end else if (r_len_sz != 4'd0) begin
                            n_phase = PH_EXTLEN;
                        end else begin
                            fin = 1'b1;
                            fin_idx = v;
                            fin_off = r_hoff;
                        end
                    end
                    PH_EXTOFF: begin
                        n_hoff = v;
                        if (r_len_sz != 4'd0) begin
                            n_phase = PH_EXTLEN;
                        end else begin
                            fin = 1'b1;
                            fin_idx = r_hidx;
                            fin_off = v;
                        end
                    end
                    PH_EXTLEN: begin
                        fin = 1'b1;
                        fin_len = v;
                        fin_idx = r_hidx;
                        fin_off = r_hoff;
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase

                // end of one extent
                if (fin) begin
                    n_exts = ext_dec;
                    res_v = 1'b1;
                    res.kind = KIND_EXTENT;
                    res.item_id = r_hid;
                    res.method = r_hmeth;
                    res.data_ref = r_hdref;
                    res.base_offset = r_hbase;
                    res.ext_index = fin_idx;
                    res.ext_offset = fin_off;
                    res.ext_length = fin_len;
                    res.last_item = (ext_dec == 16'd0);
                    res.last_box = (ext_dec == 16'd0) && (r_items == 32'd1);
                    if (ext_dec == 16'd0) begin
                        item_end = 1'b1;
                    end else begin
                        n_hidx = '0;
                        n_hoff = '0;
                        if (wide && (r_idx_sz != 4'd0)) begin
                            n_phase = PH_EXTINDEX;
                        end else if (r_off_sz != 4'd0) begin
                            n_phase = PH_EXTOFF;
                        end else begin
                            n_phase = PH_EXTLEN;
                        end
                    end
                end

                // end of one item
                if (item_end) begin
                    n_items = r_items - 32'd1;
                    n_phase = (r_items == 32'd1) ? PH_WAIT : PH_ITEMID;
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_cnt   <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
        r_version <= n_version;
        r_off_sz  <= n_off_sz;
        r_len_sz  <= n_len_sz;
        r_base_sz <= n_base_sz;
        r_idx_sz  <= n_idx_sz;
        r_items   <= n_items;
        r_exts    <= n_exts;
        r_acc     <= n_acc;
        r_hid     <= n_hid;
        r_hmeth   <= n_hmeth;
        r_hdref   <= n_hdref;
        r_hbase   <= n_hbase;
        r_hidx    <= n_hidx;
        r_hoff    <= n_hoff;
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_v) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (res_v) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    // master side
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.ext_length, r_out.ext_offset, r_out.ext_index,
                         r_out.base_offset, r_out.data_ref, r_out.method,
                         r_out.item_id, r_out.err};
    assign o_m_tuser  = {r_out.last_item, r_out.kind};
    assign o_m_tlast  = r_out.last_box;

`ifndef SYNTHESIS
    // skid entry is only filled behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // a record is only produced by an active parser or a box start
    a_res_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_v |-> (s_fire && ((r_phase != PH_WAIT) || i_s_tuser[0])))
        else $error("record produced while waiting for a box start");

    // error records close the box and carry no item end
    a_error_closes_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_v && (res.kind == KIND_ERROR)) |=> (r_phase == PH_WAIT))
        else $error("parser still active after an error record");

    // non-error records carry a zero error code
    a_err_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind != KIND_ERROR)) |-> (r_out.err == ERR_OFFSET_SIZE))
        else $error("nonzero error code on a non-error record");

    // a record that closes the box must close its item unless it is error or empty
    a_box_end_item_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_box &&
         ((r_out.kind == KIND_EXTENT) || (r_out.kind == KIND_NOEXT))) |-> r_out.last_item)
        else $error("box ended inside an item");
`endif

endmodule
